// ===== design/wheel_gear_command_controller_top_defines.svh =====
// assertion macros for the wheel gear command controller
// used by design/wheel_gear_command_controller_top.sv; needs ports clock and reset in scope
`ifndef WHEEL_GEAR_COMMAND_CONTROLLER_TOP_DEFINES_SVH
`define WHEEL_GEAR_COMMAND_CONTROLLER_TOP_DEFINES_SVH
`ifndef SYNTH
// condition implies consequence in the same cycle
`define WGCC_ASSERT_IMPL(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);
// condition implies consequence in the next cycle
`define WGCC_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);
`else
`define WGCC_ASSERT_IMPL(label, cond, cons, msg)
`define WGCC_ASSERT_NEXT(label, cond, cons, msg)
`endif
`endif

// ===== design/wgcc_pkg.sv =====
// types, codes and reset constants of the wheel gear command controller
// no dependencies; imported by wgcc_step and the top level
`default_nettype none
package wgcc_pkg;

   typedef logic signed [2:0] gear_type;

   typedef enum logic {
      OP_COMMAND = 1'b0,
      OP_TICK    = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_SPEED_LOW     = 3'd0,
      CSR_SPEED_MID     = 3'd1,
      CSR_SPEED_HIGH    = 3'd2,
      CSR_CIRCLE_LENGTH = 3'd3,
      CSR_CIRCLE_SPLIT  = 3'd4
   } csr_index_type;

   // command characters
   localparam logic [7:0] CMD_UP       = 8'h77; // w
   localparam logic [7:0] CMD_DOWN     = 8'h73; // s
   localparam logic [7:0] CMD_CURVE_L  = 8'h71; // q
   localparam logic [7:0] CMD_CURVE_R  = 8'h65; // e
   localparam logic [7:0] CMD_SPIN_R   = 8'h64; // d
   localparam logic [7:0] CMD_SPIN_L   = 8'h61; // a
   localparam logic [7:0] CMD_CIRCLE   = 8'h38; // 8

   // direction bits per wheel, forward and backward
   localparam logic [7:0] DIR_RF_FWD = 8'h80;
   localparam logic [7:0] DIR_RF_BCK = 8'h02;
   localparam logic [7:0] DIR_RB_FWD = 8'h20;
   localparam logic [7:0] DIR_RB_BCK = 8'h10;
   localparam logic [7:0] DIR_LF_FWD = 8'h04;
   localparam logic [7:0] DIR_LF_BCK = 8'h01;
   localparam logic [7:0] DIR_LB_FWD = 8'h40;
   localparam logic [7:0] DIR_LB_BCK = 8'h08;

   localparam int SPEED_W   = 20;
   localparam int COUNTER_W = 9;

   // register reset values
   localparam logic [SPEED_W-1:0]   SPEED_LOW_RST     = 20'd393216;
   localparam logic [SPEED_W-1:0]   SPEED_MID_RST     = 20'd786432;
   localparam logic [SPEED_W-1:0]   SPEED_HIGH_RST    = 20'd1048575;
   localparam logic [COUNTER_W-1:0] CIRCLE_LENGTH_RST = 9'd432;
   localparam logic [COUNTER_W-1:0] CIRCLE_SPLIT_RST  = 9'd182;

   typedef struct packed {
      gear_type               lf;
      gear_type               lb;
      gear_type               rf;
      gear_type               rb;
      logic                   turning;
      logic [COUNTER_W-1:0]   counter;
   } drive_state_type;

   typedef struct packed {
      logic [SPEED_W-1:0]     speed_low;
      logic [SPEED_W-1:0]     speed_mid;
      logic [SPEED_W-1:0]     speed_high;
      logic [COUNTER_W-1:0]   circle_length;
      logic [COUNTER_W-1:0]   circle_split;
   } csr_type;

   typedef struct packed {
      logic [7:0]             direction_bits;
      logic [SPEED_W-1:0]     speed_right_front;
      logic [SPEED_W-1:0]     speed_left_back;
      logic [SPEED_W-1:0]     speed_left_front;
      logic [SPEED_W-1:0]     speed_right_back;
   } result_type;

endpackage
`default_nettype wire

// ===== design/wgcc_step.sv =====
// next gear state and result word for one command or tick
// depends on wgcc_pkg
`default_nettype none
module wgcc_step (
   input  wire wgcc_pkg::drive_state_type state_i,
   input  wire wgcc_pkg::csr_type         csr_i,
   input  wire logic                      opcode_i,
   input  wire logic [7:0]                command_i,
   output wgcc_pkg::drive_state_type      state_o,
   output logic                           result_valid_o,
   output wgcc_pkg::result_type           result_o
);
   import wgcc_pkg::*;

   logic signed [3:0] lf_tgt, lb_tgt, rf_tgt, rb_tgt;
   gear_type          lf_new, lb_new, rf_new, rb_new;
   logic [COUNTER_W-1:0] cnt_dec;

   // widen a gear by one sign bit
   function automatic logic signed [3:0] widen(input gear_type g);
      return $signed({g[2], g});
   endfunction

   // saturate to plus or minus three
   function automatic gear_type clamp(input logic signed [3:0] g);
      gear_type r;
      if (g > 4'sd3)       r = 3'sd3;
      else if (g < -4'sd3) r = -3'sd3;
      else                 r = g[2:0];
      return r;
   endfunction

   // pwm value from gear magnitude
   function automatic logic [SPEED_W-1:0] pwm(input gear_type g, input csr_type c);
      logic signed [3:0] w;
      logic [3:0]        m;
      logic [SPEED_W-1:0] r;
      w = widen(g);
      m = (w < 0) ? 4'(-w) : 4'(w);
      case (m)
         4'd0:    r = '0;
         4'd1:    r = c.speed_low;
         4'd2:    r = c.speed_mid;
         default: r = c.speed_high;
      endcase
      return r;
   endfunction

   assign cnt_dec = state_i.counter - 9'd1;

   // command and tick decode
   always_comb begin
      state_o        = state_i;
      result_valid_o = 1'b0;
      lf_tgt = '0;
      lb_tgt = '0;
      rf_tgt = '0;
      rb_tgt = '0;
      if (opcode_i == OP_TICK) begin
         if (state_i.counter != '0) begin
            result_valid_o  = 1'b1;
            state_o.turning = 1'b1;
            if (state_i.counter >= csr_i.circle_split) begin
               // right curve
               state_o.counter = cnt_dec;
               lf_tgt = 4'sd3; lb_tgt = 4'sd3; rf_tgt = 4'sd0; rb_tgt = 4'sd1;
            end else begin
               // left curve, reload at the end of the circle
               state_o.counter = (cnt_dec == '0) ? csr_i.circle_length : cnt_dec;
               lf_tgt = 4'sd0; lb_tgt = 4'sd1; rf_tgt = 4'sd3; rb_tgt = 4'sd3;
            end
         end
      end else begin
         unique case (command_i)
            CMD_UP: begin
               result_valid_o  = 1'b1;
               state_o.counter = '0;
               state_o.turning = 1'b0;
               if (state_i.turning) begin
                  lf_tgt = 4'sd2; lb_tgt = 4'sd2; rf_tgt = 4'sd2; rb_tgt = 4'sd2;
               end else begin
                  lf_tgt = widen(state_i.lf) + 4'sd1;
                  lb_tgt = widen(state_i.lb) + 4'sd1;
                  rf_tgt = widen(state_i.rf) + 4'sd1;
                  rb_tgt = widen(state_i.rb) + 4'sd1;
               end
            end
            CMD_DOWN: begin
               result_valid_o  = 1'b1;
               state_o.counter = '0;
               state_o.turning = 1'b0;
               if (!state_i.turning) begin
                  lf_tgt = widen(state_i.lf) - 4'sd1;
                  lb_tgt = widen(state_i.lb) - 4'sd1;
                  rf_tgt = widen(state_i.rf) - 4'sd1;
                  rb_tgt = widen(state_i.rb) - 4'sd1;
               end
            end
            CMD_CURVE_L: begin
               result_valid_o  = 1'b1;
               state_o.turning = 1'b1;
               lf_tgt = 4'sd0; lb_tgt = 4'sd1; rf_tgt = 4'sd3; rb_tgt = 4'sd3;
            end
            CMD_CURVE_R: begin
               result_valid_o  = 1'b1;
               state_o.turning = 1'b1;
               lf_tgt = 4'sd3; lb_tgt = 4'sd3; rf_tgt = 4'sd0; rb_tgt = 4'sd1;
            end
            CMD_SPIN_R: begin
               result_valid_o  = 1'b1;
               state_o.counter = '0;
               state_o.turning = 1'b1;
               lf_tgt = 4'sd2; lb_tgt = 4'sd2; rf_tgt = -4'sd2; rb_tgt = -4'sd2;
            end
            CMD_SPIN_L: begin
               result_valid_o  = 1'b1;
               state_o.counter = '0;
               state_o.turning = 1'b1;
               lf_tgt = -4'sd2; lb_tgt = -4'sd2; rf_tgt = 4'sd2; rb_tgt = 4'sd2;
            end
            CMD_CIRCLE: begin
               state_o.counter = csr_i.circle_length;
            end
            default: begin
               // stop
               result_valid_o  = 1'b1;
               state_o.counter = '0;
               state_o.turning = 1'b0;
            end
         endcase
      end
      if (result_valid_o) begin
         state_o.lf = lf_new;
         state_o.lb = lb_new;
         state_o.rf = rf_new;
         state_o.rb = rb_new;
      end
   end

   assign lf_new = clamp(lf_tgt);
   assign lb_new = clamp(lb_tgt);
   assign rf_new = clamp(rf_tgt);
   assign rb_new = clamp(rb_tgt);

   // result word from the new gears
   always_comb begin
      result_o.direction_bits = (rf_new[2] ? DIR_RF_BCK : DIR_RF_FWD)
                              | (rb_new[2] ? DIR_RB_BCK : DIR_RB_FWD)
                              | (lf_new[2] ? DIR_LF_BCK : DIR_LF_FWD)
                              | (lb_new[2] ? DIR_LB_BCK : DIR_LB_FWD);
      result_o.speed_right_front = pwm(rf_new, csr_i);
      result_o.speed_left_back   = pwm(lb_new, csr_i);
      result_o.speed_left_front  = pwm(lf_new, csr_i);
      result_o.speed_right_back  = pwm(rb_new, csr_i);
   end

endmodule
`default_nettype wire

// ===== design/wheel_gear_command_controller_top.sv =====
// top level of the wheel gear command controller: input word, state and result registers
// depends on wgcc_pkg, wgcc_step and wheel_gear_command_controller_top_defines.svh
//
//   channel   ports                         direction
//   req       req_valid/req_ready + fields  in: command byte or tick
//   rsp       rsp_valid/rsp_ready + fields  out: direction byte and four speeds
//   csr       csr_valid/csr_ready, index    in: register write, always ready
//
// one word per cycle unless a waiting result stalls it: a word is held in the
// input register, then the step logic updates the state and, if the word gives
// a result, loads the result register; rsp_valid rises with that load.
// while a result waits the input register takes one more word and holds it;
// it stalls only when it is full and the result register cannot be emptied.
// reset is synchronous and restores gears, counter and register defaults.
`default_nettype none
`include "wheel_gear_command_controller_top_defines.svh"
module wheel_gear_command_controller_top (
   input  wire  logic                          clock,
   input  wire  logic                          reset,
   input  wire  logic                          req_valid,
   output logic                                req_ready,
   input  wire  logic                          req_opcode,
   input  wire  logic [7:0]                    req_command_byte,
   output logic                                rsp_valid,
   input  wire  logic                          rsp_ready,
   output logic [7:0]                          rsp_direction_bits,
   output logic [wgcc_pkg::SPEED_W-1:0]        rsp_speed_right_front,
   output logic [wgcc_pkg::SPEED_W-1:0]        rsp_speed_left_back,
   output logic [wgcc_pkg::SPEED_W-1:0]        rsp_speed_left_front,
   output logic [wgcc_pkg::SPEED_W-1:0]        rsp_speed_right_back,
   input  wire  logic                          csr_valid,
   output logic                                csr_ready,
   input  wire  logic [2:0]                    csr_index,
   input  wire  logic [wgcc_pkg::SPEED_W-1:0]  csr_data
);
   import wgcc_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic            in_opcode_ff;
   logic [7:0]      in_command_ff;
   drive_state_type state_ff, state_in, step_state;
   csr_type         csr_ff, csr_in;
   logic            rsp_valid_ff, rsp_valid_in;
   result_type      result_ff, step_result;
   logic            step_valid;
   logic            advance;

   // handshakes
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   wgcc_step u_step (
      .state_i        (state_ff),
      .csr_i          (csr_ff),
      .opcode_i       (in_opcode_ff),
      .command_i      (in_command_ff),
      .state_o        (step_state),
      .result_valid_o (step_valid),
      .result_o       (step_result)
   );

   // next values
   always_comb begin
      in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
      state_in     = advance ? step_state : state_ff;
      rsp_valid_in = (advance && step_valid) || (rsp_valid_ff && !rsp_ready);
      csr_in       = csr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SPEED_LOW:     csr_in.speed_low     = csr_data;
            CSR_SPEED_MID:     csr_in.speed_mid     = csr_data;
            CSR_SPEED_HIGH:    csr_in.speed_high    = csr_data;
            CSR_CIRCLE_LENGTH: csr_in.circle_length = csr_data[COUNTER_W-1:0];
            CSR_CIRCLE_SPLIT:  csr_in.circle_split  = csr_data[COUNTER_W-1:0];
            default:           csr_in = csr_ff;
         endcase
      end
   end

   // control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         csr_ff.speed_low     <= SPEED_LOW_RST;
         csr_ff.speed_mid     <= SPEED_MID_RST;
         csr_ff.speed_high    <= SPEED_HIGH_RST;
         csr_ff.circle_length <= CIRCLE_LENGTH_RST;
         csr_ff.circle_split  <= CIRCLE_SPLIT_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         csr_ff       <= csr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_opcode_ff  <= req_opcode;
         in_command_ff <= req_command_byte;
      end
      if (advance && step_valid) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_direction_bits    = result_ff.direction_bits;
   assign rsp_speed_right_front = result_ff.speed_right_front;
   assign rsp_speed_left_back   = result_ff.speed_left_back;
   assign rsp_speed_left_front  = result_ff.speed_left_front;
   assign rsp_speed_right_back  = result_ff.speed_right_back;

   // checks
   `WGCC_ASSERT_IMPL(a_gear_lf, 1'b1, state_ff.lf != 3'b100, "left front gear out of range")
   `WGCC_ASSERT_IMPL(a_gear_lb, 1'b1, state_ff.lb != 3'b100, "left back gear out of range")
   `WGCC_ASSERT_IMPL(a_gear_rf, 1'b1, state_ff.rf != 3'b100, "right front gear out of range")
   `WGCC_ASSERT_IMPL(a_gear_rb, 1'b1, state_ff.rb != 3'b100, "right back gear out of range")
   `WGCC_ASSERT_NEXT(a_word_held, in_valid_ff && !advance, in_valid_ff, "input word lost")
   `WGCC_ASSERT_NEXT(a_result_loaded, advance && step_valid, rsp_valid_ff, "result not shown")

endmodule
`default_nettype wire
